// ===== hw/rtl/oqbo_pkg.sv =====
// Shared widths and types for the quad-versus-box overlap pipeline.
// No dependencies; imported by oriented_quad_box_overlap and tb_top.
package oqbo_pkg;

    localparam int COORD_BITS    = 16;
    localparam int NUM_FIELDS    = 12;
    localparam int NUM_CORNERS   = 4;
    localparam int NUM_AXES      = 2;
    localparam int DIFF_BITS     = COORD_BITS + 1;
    localparam int PROD_BITS     = COORD_BITS + DIFF_BITS;
    localparam int SUM_BITS      = PROD_BITS + 1;
    localparam int IN_DATA_BITS  = ((NUM_FIELDS * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = 8;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [SUM_BITS-1:0]   sum_t;

endpackage

// ===== hw/rtl/oriented_quad_box_overlap.sv =====
// Quad-versus-box strict overlap test (separating axes), five-stage pipeline.
// Depends on oqbo_pkg for widths and types.
//
// Usage:
//   Input channel s_axis_*: one item per handshake, twelve signed Q12.4
//   coordinates packed in s_axis_tdata (corner0_x in the lowest bits, then
//   corner0_y .. corner3_y, box_left, box_right, box_top, box_bottom).
//   Output channel m_axis_*: one item per input item, overlap in bit 0 of
//   m_axis_tdata, upper bits zero. Results leave in input order.
//   Registered stages between input acceptance and m_axis_tvalid:
//     stage 1: edge normals and quad x/y extents
//     stage 2: products of corners and box bounds with both normals
//     stage 3: per-corner projections and box projection interval
//     stage 4: quad projection min/max per axis
//     stage 5: interval compares, result register
//   Throughput: one item per cycle when the output is not stalled. Each stage
//   holds its item only while the stage after it is full and stalled, so
//   bubbles close up under output backpressure and the input stays ready
//   until all five stages hold items.
//   Reset clears every valid bit; no item is in flight afterwards.
module oriented_quad_box_overlap
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
    // corner3_x, corner3_y, box_left, box_right, box_top, box_bottom
    input  logic [oqbo_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // overlap
    output logic [oqbo_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);
    import oqbo_pkg::*;

    // Stage valid bits and per-stage load enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    // Stage 1 payload
    coord_t qx1_reg [NUM_CORNERS];
    coord_t qy1_reg [NUM_CORNERS];
    coord_t left1_reg, right1_reg, top1_reg, bottom1_reg;
    coord_t xmin1_reg, xmax1_reg, ymin1_reg, ymax1_reg;
    diff_t  nx1_reg [NUM_AXES];
    diff_t  ny1_reg [NUM_AXES];

    // Stage 2 payload
    prod_t  qpx2_reg [NUM_AXES][NUM_CORNERS];
    prod_t  qpy2_reg [NUM_AXES][NUM_CORNERS];
    prod_t  lnx2_reg [NUM_AXES];
    prod_t  rnx2_reg [NUM_AXES];
    prod_t  tny2_reg [NUM_AXES];
    prod_t  bny2_reg [NUM_AXES];
    logic   aabb2_reg;

    // Stage 3 payload
    sum_t   qp3_reg [NUM_AXES][NUM_CORNERS];
    sum_t   blo3_reg [NUM_AXES];
    sum_t   bhi3_reg [NUM_AXES];
    logic   aabb3_reg;

    // Stage 4 payload
    sum_t   qlo4_reg [NUM_AXES];
    sum_t   qhi4_reg [NUM_AXES];
    sum_t   blo4_reg [NUM_AXES];
    sum_t   bhi4_reg [NUM_AXES];
    logic   aabb4_reg;

    // Stage 5 (output) payload
    logic   overlap_reg;

    // Combinational next values
    coord_t in_qx [NUM_CORNERS];
    coord_t in_qy [NUM_CORNERS];
    coord_t xmin_next, xmax_next, ymin_next, ymax_next;
    diff_t  nx_next [NUM_AXES];
    diff_t  ny_next [NUM_AXES];
    logic   aabb_next;
    sum_t   qp_next [NUM_AXES][NUM_CORNERS];
    sum_t   blo_next [NUM_AXES];
    sum_t   bhi_next [NUM_AXES];
    sum_t   qlo_next [NUM_AXES];
    sum_t   qhi_next [NUM_AXES];
    logic   overlap_next;

    // A stage may load when it is empty or its content moves on this cycle
    assign rdy5 = !v5_reg || m_axis_tready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign s_axis_tready = rdy1;
    assign m_axis_tvalid = v5_reg;
    assign m_axis_tdata  = {(OUT_DATA_BITS-1)'(0), overlap_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= s_axis_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // ---------------- Stage 1: unpack, normals, quad extents ----------------
    always_comb
    begin
        for (int i = 0; i < NUM_CORNERS; i++)
        begin
            in_qx[i] = coord_t'(s_axis_tdata[(2*i)*COORD_BITS +: COORD_BITS]);
            in_qy[i] = coord_t'(s_axis_tdata[(2*i+1)*COORD_BITS +: COORD_BITS]);
        end
        // n0 is perpendicular to corner1 - corner0, n1 to corner2 - corner1
        for (int a = 0; a < NUM_AXES; a++)
        begin
            nx_next[a] = diff_t'(in_qy[a]) - diff_t'(in_qy[a+1]);
            ny_next[a] = diff_t'(in_qx[a+1]) - diff_t'(in_qx[a]);
        end
        xmin_next = (in_qx[0] < in_qx[1]) ? in_qx[0] : in_qx[1];
        xmax_next = (in_qx[0] > in_qx[1]) ? in_qx[0] : in_qx[1];
        ymin_next = (in_qy[0] < in_qy[1]) ? in_qy[0] : in_qy[1];
        ymax_next = (in_qy[0] > in_qy[1]) ? in_qy[0] : in_qy[1];
        for (int i = 2; i < NUM_CORNERS; i++)
        begin
            if (in_qx[i] < xmin_next) xmin_next = in_qx[i];
            if (in_qx[i] > xmax_next) xmax_next = in_qx[i];
            if (in_qy[i] < ymin_next) ymin_next = in_qy[i];
            if (in_qy[i] > ymax_next) ymax_next = in_qy[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && s_axis_tvalid)
        begin
            for (int i = 0; i < NUM_CORNERS; i++)
            begin
                qx1_reg[i] <= in_qx[i];
                qy1_reg[i] <= in_qy[i];
            end
            for (int a = 0; a < NUM_AXES; a++)
            begin
                nx1_reg[a] <= nx_next[a];
                ny1_reg[a] <= ny_next[a];
            end
            left1_reg   <= coord_t'(s_axis_tdata[8*COORD_BITS +: COORD_BITS]);
            right1_reg  <= coord_t'(s_axis_tdata[9*COORD_BITS +: COORD_BITS]);
            top1_reg    <= coord_t'(s_axis_tdata[10*COORD_BITS +: COORD_BITS]);
            bottom1_reg <= coord_t'(s_axis_tdata[11*COORD_BITS +: COORD_BITS]);
            xmin1_reg   <= xmin_next;
            xmax1_reg   <= xmax_next;
            ymin1_reg   <= ymin_next;
            ymax1_reg   <= ymax_next;
        end
    end

    // ---------------- Stage 2: products, extent test ----------------
    // The box corners combine {left,right} x with {top,bottom} y, so only
    // four box products per axis are needed.
    assign aabb_next = (xmax1_reg > left1_reg) && (xmin1_reg < right1_reg) &&
                       (ymax1_reg > top1_reg) && (ymin1_reg < bottom1_reg);

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                for (int i = 0; i < NUM_CORNERS; i++)
                begin
                    qpx2_reg[a][i] <= prod_t'(qx1_reg[i]) * prod_t'(nx1_reg[a]);
                    qpy2_reg[a][i] <= prod_t'(qy1_reg[i]) * prod_t'(ny1_reg[a]);
                end
                lnx2_reg[a] <= prod_t'(left1_reg)   * prod_t'(nx1_reg[a]);
                rnx2_reg[a] <= prod_t'(right1_reg)  * prod_t'(nx1_reg[a]);
                tny2_reg[a] <= prod_t'(top1_reg)    * prod_t'(ny1_reg[a]);
                bny2_reg[a] <= prod_t'(bottom1_reg) * prod_t'(ny1_reg[a]);
            end
            aabb2_reg <= aabb_next;
        end
    end

    // ---------------- Stage 3: projections ----------------
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            for (int i = 0; i < NUM_CORNERS; i++)
                qp_next[a][i] = sum_t'(qpx2_reg[a][i]) + sum_t'(qpy2_reg[a][i]);
            blo_next[a] = sum_t'((lnx2_reg[a] < rnx2_reg[a]) ? lnx2_reg[a] : rnx2_reg[a]) +
                          sum_t'((tny2_reg[a] < bny2_reg[a]) ? tny2_reg[a] : bny2_reg[a]);
            bhi_next[a] = sum_t'((lnx2_reg[a] > rnx2_reg[a]) ? lnx2_reg[a] : rnx2_reg[a]) +
                          sum_t'((tny2_reg[a] > bny2_reg[a]) ? tny2_reg[a] : bny2_reg[a]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                for (int i = 0; i < NUM_CORNERS; i++)
                    qp3_reg[a][i] <= qp_next[a][i];
                blo3_reg[a] <= blo_next[a];
                bhi3_reg[a] <= bhi_next[a];
            end
            aabb3_reg <= aabb2_reg;
        end
    end

    // ---------------- Stage 4: quad interval per axis ----------------
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            qlo_next[a] = qp3_reg[a][0];
            qhi_next[a] = qp3_reg[a][0];
            for (int i = 1; i < NUM_CORNERS; i++)
            begin
                if (qp3_reg[a][i] < qlo_next[a]) qlo_next[a] = qp3_reg[a][i];
                if (qp3_reg[a][i] > qhi_next[a]) qhi_next[a] = qp3_reg[a][i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                qlo4_reg[a] <= qlo_next[a];
                qhi4_reg[a] <= qhi_next[a];
                blo4_reg[a] <= blo3_reg[a];
                bhi4_reg[a] <= bhi3_reg[a];
            end
            aabb4_reg <= aabb3_reg;
        end
    end

    // ---------------- Stage 5: strict interval tests ----------------
    // Touching intervals fail; a zero axis projects everything to 0 and fails.
    always_comb
    begin
        overlap_next = aabb4_reg;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (!((qhi4_reg[a] > blo4_reg[a]) && (qlo4_reg[a] < bhi4_reg[a])))
                overlap_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy5 && v4_reg)
            overlap_reg <= overlap_next;
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for oriented_quad_box_overlap: directed and random items,
// expected overlap flags from a local predictor. Needs oqbo_pkg and the block's RTL.
module tb_top;

    import oqbo_pkg::*;

    // Slowest correct stretch without any handshake is a sender gap plus the pipeline
    // depth, or a receiver stall; allow many times that.
    localparam int STALL_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 900;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_CAP   = 10;

    // How the expected flag of a row is obtained: predicted, or typed in as known.
    typedef enum logic [1:0] {VERDICT_PREDICT, VERDICT_MISS, VERDICT_HIT} verdict_t;

    typedef struct packed {
        verdict_t                  verdict;
        logic [IN_DATA_BITS-1:0]   coords;
    } quad_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
    // corner3_x, corner3_y, box_left, box_right, box_top, box_bottom
    logic [IN_DATA_BITS-1:0]    s_axis_tdata = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    // overlap
    logic [OUT_DATA_BITS-1:0]   m_axis_tdata;

    // Travels beside s_axis_tdata so the scoreboard knows how to form the expectation.
    verdict_t                   row_verdict = VERDICT_PREDICT;

    bit                         overlap_due[$];
    bit                         in_steady = 1'b0;
    int                         items_in = 0;
    int                         results_seen = 0;
    int                         hits_seen = 0;
    int                         fault_count = 0;

    oriented_quad_box_overlap dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Predict the overlap flag: bounding-extent test first, then both edge normals,
    // projecting quad and box corners exactly at 34 bits and comparing strictly.
    function automatic bit predict_overlap(input logic [IN_DATA_BITS-1:0] word);
        coord_t qx[4], qy[4], px[8], py[8];
        coord_t left, right, top, bottom, xlo, xhi, ylo, yhi;
        diff_t  nx[2], ny[2];
        sum_t   p, qlo, qhi, blo, bhi;
        bit     hit;
        int     k, a;
        for (k = 0; k < NUM_CORNERS; k++)
        begin
            qx[k] = word[(2*k)*COORD_BITS +: COORD_BITS];
            qy[k] = word[(2*k+1)*COORD_BITS +: COORD_BITS];
        end
        left   = word[8*COORD_BITS +: COORD_BITS];
        right  = word[9*COORD_BITS +: COORD_BITS];
        top    = word[10*COORD_BITS +: COORD_BITS];
        bottom = word[11*COORD_BITS +: COORD_BITS];
        xlo = qx[0]; xhi = qx[0]; ylo = qy[0]; yhi = qy[0];
        for (k = 1; k < NUM_CORNERS; k++)
        begin
            if (qx[k] < xlo) xlo = qx[k];
            if (qx[k] > xhi) xhi = qx[k];
            if (qy[k] < ylo) ylo = qy[k];
            if (qy[k] > yhi) yhi = qy[k];
        end
        hit = (xhi > left) && (xlo < right) && (yhi > top) && (ylo < bottom);
        // Points 0..3 are the quad, 4..7 the box taken as given (no swap when inverted).
        for (k = 0; k < NUM_CORNERS; k++)
        begin
            px[k] = qx[k];
            py[k] = qy[k];
        end
        px[4] = left;  py[4] = top;
        px[5] = right; py[5] = top;
        px[6] = right; py[6] = bottom;
        px[7] = left;  py[7] = bottom;
        nx[0] = diff_t'(qy[0]) - diff_t'(qy[1]);
        ny[0] = diff_t'(qx[1]) - diff_t'(qx[0]);
        nx[1] = diff_t'(qy[1]) - diff_t'(qy[2]);
        ny[1] = diff_t'(qx[2]) - diff_t'(qx[1]);
        for (a = 0; a < NUM_AXES; a++)
        begin
            qlo = '0; qhi = '0; blo = '0; bhi = '0;
            for (k = 0; k < 8; k++)
            begin
                p = sum_t'(px[k]) * sum_t'(nx[a]) + sum_t'(py[k]) * sum_t'(ny[a]);
                if (k < NUM_CORNERS)
                begin
                    if (k == 0 || p < qlo) qlo = p;
                    if (k == 0 || p > qhi) qhi = p;
                end
                else
                begin
                    if (k == NUM_CORNERS || p < blo) blo = p;
                    if (k == NUM_CORNERS || p > bhi) bhi = p;
                end
            end
            if (!((qhi > blo) && (qlo < bhi)))
                hit = 1'b0;
        end
        return hit;
    endfunction

    // Pack twelve raw Q12.4 values into one item, corner0_x in the lowest bits.
    function automatic quad_row_t make_row(input verdict_t v,
                                           input int c0x, input int c0y,
                                           input int c1x, input int c1y,
                                           input int c2x, input int c2y,
                                           input int c3x, input int c3y,
                                           input int lft, input int rgt,
                                           input int top, input int bot);
        quad_row_t row;
        row.verdict = v;
        row.coords  = {coord_t'(bot), coord_t'(top), coord_t'(rgt), coord_t'(lft),
                       coord_t'(c3y), coord_t'(c3x), coord_t'(c2y), coord_t'(c2x),
                       coord_t'(c1y), coord_t'(c1x), coord_t'(c0y), coord_t'(c0x)};
        return row;
    endfunction

    function automatic int spread(input int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    // Draw one random item: mostly a parallelogram or loose quad near a box, plus
    // edge-flush boxes, repeated corners, inverted boxes and raw bit noise.
    function automatic quad_row_t random_row();
        quad_row_t row;
        int        kind, span, cx, cy, ux, uy, vx, vy, scale, bx, by, hw, hh, tmp;
        int        lft, rgt, top, bot, xlo, xhi, ylo, yhi, k;
        int        x[4], y[4];
        kind = $urandom_range(0, 99);
        if (kind >= 86)
        begin
            row.verdict = VERDICT_PREDICT;
            for (k = 0; k < NUM_FIELDS; k++)
            begin
                case ($urandom_range(0, 7))
                    0:       row.coords[k*COORD_BITS +: COORD_BITS] = 16'h8000;
                    1:       row.coords[k*COORD_BITS +: COORD_BITS] = 16'h7fff;
                    default: row.coords[k*COORD_BITS +: COORD_BITS] = COORD_BITS'($urandom);
                endcase
            end
            return row;
        end
        span = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 8000) : $urandom_range(1, 512);
        cx = spread(4000);
        cy = spread(4000);
        if ($urandom_range(0, 3) == 0)
        begin
            for (k = 0; k < NUM_CORNERS; k++)
            begin
                x[k] = cx + spread(span);
                y[k] = cy + spread(span);
            end
        end
        else
        begin
            ux = spread(span);
            uy = spread(span);
            scale = $urandom_range(1, 8);
            vx = -uy * scale / 4;
            vy = ux * scale / 4;
            x[0] = cx - ux - vx; y[0] = cy - uy - vy;
            x[1] = cx + ux - vx; y[1] = cy + uy - vy;
            x[2] = cx + ux + vx; y[2] = cy + uy + vy;
            x[3] = cx - ux + vx; y[3] = cy - uy + vy;
        end
        // Flip the winding so both normal directions occur.
        if ($urandom_range(0, 1) == 1)
        begin
            tmp = x[1]; x[1] = x[3]; x[3] = tmp;
            tmp = y[1]; y[1] = y[3]; y[3] = tmp;
        end
        bx = cx + spread(2 * span);
        by = cy + spread(2 * span);
        hw = $urandom_range(0, span);
        hh = $urandom_range(0, span);
        lft = bx - hw; rgt = bx + hw; top = by - hh; bot = by + hh;
        if (kind >= 60 && kind < 70)
        begin
            // Butt the box against one side of the quad's extent: contact only.
            xlo = x[0]; xhi = x[0]; ylo = y[0]; yhi = y[0];
            for (k = 1; k < NUM_CORNERS; k++)
            begin
                if (x[k] < xlo) xlo = x[k];
                if (x[k] > xhi) xhi = x[k];
                if (y[k] < ylo) ylo = y[k];
                if (y[k] > yhi) yhi = y[k];
            end
            case ($urandom_range(0, 3))
                0:       begin lft = xhi; rgt = xhi + hw + 1; end
                1:       begin rgt = xlo; lft = xlo - hw - 1; end
                2:       begin top = yhi; bot = yhi + hh + 1; end
                default: begin bot = ylo; top = ylo - hh - 1; end
            endcase
        end
        else if (kind >= 70 && kind < 78)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                x[1] = x[0]; y[1] = y[0];
            end
            else
            begin
                x[2] = x[1]; y[2] = y[1];
            end
        end
        else if (kind >= 78)
        begin
            if ($urandom_range(0, 2) != 1)
            begin
                tmp = lft; lft = rgt; rgt = tmp;
            end
            if ($urandom_range(0, 2) != 0)
            begin
                tmp = top; top = bot; bot = tmp;
            end
        end
        return make_row(VERDICT_PREDICT, x[0], y[0], x[1], y[1], x[2], y[2], x[3], y[3],
                        lft, rgt, top, bot);
    endfunction

    // Offer one item after a random gap; keep tvalid high across back-to-back items.
    task automatic send_row(input quad_row_t row);
        int gap;
        gap = in_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= row.coords;
        row_verdict   <= row.verdict;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
    endtask

    // Drop tvalid and hold the sender until every outstanding flag has come back.
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        while (overlap_due.size() != 0) @(negedge clk);
    endtask

    // Scoreboard: queue the expectation of each accepted item, then check each result.
    always @(posedge clk)
    begin : scoreboard
        logic [OUT_DATA_BITS-1:0] want;
        bit                       flag;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                case (row_verdict)
                    VERDICT_HIT:  flag = 1'b1;
                    VERDICT_MISS: flag = 1'b0;
                    default:      flag = predict_overlap(s_axis_tdata);
                endcase
                overlap_due.push_back(flag);
                items_in++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (m_axis_tdata[0] === 1'b1)
                    hits_seen++;
                if (overlap_due.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_CAP)
                        $display("result %0d arrived with nothing pending, tdata %02h",
                                 results_seen, m_axis_tdata);
                end
                else
                begin
                    flag = overlap_due.pop_front();
                    want = '0;
                    want[0] = flag;
                    if (m_axis_tdata !== want)
                    begin
                        fault_count++;
                        if (fault_count <= REPORT_CAP)
                            $display("result %0d: expected tdata %02h, got %02h",
                                     results_seen, want, m_axis_tdata);
                    end
                end
            end
        end
    end

    // Receiver: stall a random number of cycles before each result, with runs of
    // back-to-back acceptance in between.
    initial
    begin : receiver
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = (((results_seen / 40) % 4) == 1) ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
        end
    end

    // Watchdog: end the run if neither side moves an item for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        quad_row_t directed[$];
        int        n;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows: contact cases, degenerate axes, inverted boxes, extremes,
        // and a rotated diamond that only a diagonal axis separates.
        directed.push_back(make_row(VERDICT_HIT,  0, 0, 256, 0, 256, 256, 0, 256,
                                    128, 384, 128, 384));
        directed.push_back(make_row(VERDICT_MISS, 0, 0, 256, 0, 256, 256, 0, 256,
                                    256, 512, 0, 256));
        directed.push_back(make_row(VERDICT_MISS, 0, 0, 256, 0, 256, 256, 0, 256,
                                    256, 512, 256, 512));
        directed.push_back(make_row(VERDICT_MISS, 0, 0, 0, 0, 256, 256, 0, 256,
                                    -1000, 1000, -1000, 1000));
        directed.push_back(make_row(VERDICT_MISS, 0, 0, 256, 0, 256, 0, 0, 256,
                                    -1000, 1000, -1000, 1000));
        directed.push_back(make_row(VERDICT_MISS, 0, 0, 256, 0, 256, 256, 0, 256,
                                    1000, -1000, -1000, 1000));
        directed.push_back(make_row(VERDICT_PREDICT, -2000, -2000, 2000, -2000, 2000, 2000,
                                    -2000, 2000, 100, -100, -100, 100));
        directed.push_back(make_row(VERDICT_MISS, 0, 0, 256, 0, 256, 256, 0, 256,
                                    -1000, 1000, 1000, -1000));
        directed.push_back(make_row(VERDICT_MISS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(VERDICT_MISS, -32768, -32768, -32768, -32768,
                                    -32768, -32768, -32768, -32768,
                                    -32768, -32768, -32768, -32768));
        directed.push_back(make_row(VERDICT_MISS, 32767, 32767, 32767, 32767,
                                    32767, 32767, 32767, 32767,
                                    32767, 32767, 32767, 32767));
        directed.push_back(make_row(VERDICT_HIT, -32768, -32768, 32767, -32768, 32767, 32767,
                                    -32768, 32767, -16, 16, -16, 16));
        directed.push_back(make_row(VERDICT_HIT, 0, 0, 256, 0, 256, 256, 0, 256,
                                    -32768, 32767, -32768, 32767));
        directed.push_back(make_row(VERDICT_HIT, -32768, -32768, 32767, -32768, 32767, 32767,
                                    -32768, 32767, -32768, 32767, -32768, 32767));
        directed.push_back(make_row(VERDICT_MISS, 0, 0, 256, 0, 256, 256, 0, 256,
                                    10000, 12000, 10000, 12000));
        directed.push_back(make_row(VERDICT_MISS, 0, -512, 512, 0, 0, 512, -512, 0,
                                    320, 640, 320, 640));
        directed.push_back(make_row(VERDICT_MISS, 0, -512, 512, 0, 0, 512, -512, 0,
                                    256, 640, 256, 640));
        directed.push_back(make_row(VERDICT_HIT,  0, -512, 512, 0, 0, 512, -512, 0,
                                    0, 128, 0, 128));
        directed.push_back(make_row(VERDICT_PREDICT, 0, -512, -512, 0, 0, 512, 512, 0,
                                    320, 640, 320, 640));
        directed.push_back(make_row(VERDICT_PREDICT, 100, -300, 700, 0, 500, 400, -100, 100,
                                    400, 800, -400, -100));
        directed.push_back(make_row(VERDICT_PREDICT, -32768, 0, 32767, 1, 32767, 32767,
                                    -32768, 32766, 0, 16, 0, 16));
        directed.push_back(make_row(VERDICT_PREDICT, 0, 0, 256, 0, 256, 256, 0, 256,
                                    100, 100, 0, 256));
        directed.push_back(make_row(VERDICT_PREDICT, 32767, -32768, -32768, 32767,
                                    32767, 32767, -32768, -32768, -1, 1, -1, 1));

        foreach (directed[i])
            send_row(directed[i]);
        hold_until_drained();

        // Random part: alternate gapped and gap-free stretches, and drain now and then
        // so the pipeline also restarts from empty.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            in_steady = (((n / 50) % 4) == 3);
            if ((n % 300) == 299)
                hold_until_drained();
            send_row(random_row());
        end
        s_axis_tvalid <= 1'b0;

        while (overlap_due.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        fault_count += overlap_due.size();

        $display("Sent %0d items (%0d directed), got %0d flags back, %0d of them overlaps.",
                 items_in, directed.size(), results_seen, hits_seen);
        $display("Faults found: %0d.", fault_count);
        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
